>>> rtl/gqig_pkg.sv
package gqig_pkg;

    // Quotient bits of the parent-cell divide, one bit per pipeline stage
    localparam int DIV_W      = 8;
    localparam int DIV_STAGES = DIV_W;

    // Pipeline stage positions
    localparam int ST_IN    = 0;
    localparam int ST_DIV0  = 1;
    localparam int ST_P     = ST_DIV0 + DIV_STAGES;
    localparam int ST_R     = ST_P + 1;
    localparam int ST_S     = ST_R + 1;
    localparam int ST_O     = ST_S + 1;
    localparam int N_STAGES = ST_O + 1;

    localparam int IDX_W = 17;
    localparam int P_W   = 16;

    // Configuration register indexes
    localparam logic [2:0] CFG_GRID_COLS    = 3'd0;
    localparam logic [2:0] CFG_GRID_ROWS    = 3'd1;
    localparam logic [2:0] CFG_CELL_SUBDIV  = 3'd2;
    localparam logic [2:0] CFG_ACTIVE_COUNT = 3'd3;
    localparam logic [2:0] CFG_SEAM_COUNT   = 3'd4;

    // Input item modes
    localparam logic [1:0] MODE_QUAD      = 2'd0;
    localparam logic [1:0] MODE_ACTIVE_WR = 2'd1;
    localparam logic [1:0] MODE_SEAM_WR   = 2'd2;

    typedef enum logic [1:0] {
        KIND_QUAD,
        KIND_ACTIVE_WR,
        KIND_SEAM_WR
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [9:0]         tix;
        logic signed [8:0]  tval;
        logic [IDX_W-1:0]   bl;
        logic [IDX_W-1:0]   tl;
    } item_t;

    // Item presented to the table stage
    typedef struct packed {
        logic               valid;
        item_kind_t         kind;
        logic [9:0]         tix;
        logic signed [8:0]  tval;
        logic [7:0]         col;
        logic [P_W-1:0]     p;
    } tbl_req_t;

endpackage

>>> rtl/gqig_div_lane.sv
module gqig_div_lane
    import gqig_pkg::*;
(
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] stage_en,
    input  logic [DIV_W-1:0]      divisor,
    input  logic [DIV_W-1:0]      dividend,
    output logic [DIV_W-1:0]      quotient
);

    logic [DIV_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_W-1:0] num_reg [DIV_STAGES];
    logic [DIV_W-1:0] quo_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] num_in;
        logic [DIV_W-1:0] quo_in;
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W-1:0] rem_next;
        logic [DIV_W-1:0] quo_next;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // Shift in the next dividend bit, subtract when the divisor fits
        always_comb begin
            trial    = {rem_in, num_in[DIV_W-1-j]};
            ge       = (trial >= {1'b0, divisor});
            rem_next = ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
            quo_next = quo_in;
            quo_next[DIV_W-1-j] = ge;
        end

        always_ff @(posedge aclk) begin
            if (stage_en[j]) begin
                rem_reg[j] <= rem_next;
                num_reg[j] <= num_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

>>> rtl/gqig_tables.sv
module gqig_tables
    import gqig_pkg::*;
#(
    parameter int ACTIVE_DEPTH = 1024,
    parameter int MAX_SEAMS    = 8,
    localparam int AW          = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1,
    localparam int KW          = (MAX_SEAMS > 1) ? $clog2(MAX_SEAMS) : 1
)
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load_en,
    input  tbl_req_t      req,
    input  logic [7:0]    grid_cols,
    input  logic [10:0]   active_count,
    input  logic [3:0]    seam_count,
    output logic          clearing,
    output logic          act_bit,
    output logic          p_ok,
    output logic          seam_hit,
    output logic [KW-1:0] seam_rank
);

    logic                  mem [ACTIVE_DEPTH];
    logic signed [8:0]     seam_reg [MAX_SEAMS];

    logic                  clearing_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic                  act_bit_reg;
    logic                  p_ok_reg;
    logic                  seam_hit_reg;
    logic [KW-1:0]         seam_rank_reg;

    logic                  step;
    logic                  act_we;
    logic                  seam_we;
    logic [P_W-1:0]        tix_ext;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [7:0]            col1;
    logic [MAX_SEAMS-1:0]  seam_valid;
    logic [MAX_SEAMS-1:0]  seam_match;
    logic [KW-1:0]         rank_arr [MAX_SEAMS];
    logic                  hit_next;
    logic [KW-1:0]         rank_next;
    logic                  p_ok_next;

    assign step    = load_en && req.valid;
    assign act_we  = step && (req.kind == KIND_ACTIVE_WR)
                     && ({7'd0, req.tix} < 17'(ACTIVE_DEPTH));
    assign seam_we = step && (req.kind == KIND_SEAM_WR)
                     && ({7'd0, req.tix} < 17'(MAX_SEAMS));
    assign tix_ext = P_W'(req.tix);
    assign wr_addr = tix_ext[AW-1:0];
    assign rd_addr = req.p[AW-1:0];
    assign col1    = req.col + 8'd1;

    // Bitmap clear sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(ACTIVE_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (act_we) begin
            mem[wr_addr] <= (req.tval != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            act_bit_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (seam_we) begin
            seam_reg[req.tix[KW-1:0]] <= req.tval;
        end
    end

    // Rank of each seam entry among the valid ones before it; last match wins
    always_comb begin
        logic [MAX_SEAMS-1:0] below;
        for (int i = 0; i < MAX_SEAMS; i++) begin
            seam_valid[i] = (5'(i) < {1'b0, seam_count}) && !seam_reg[i][8]
                            && (seam_reg[i][7:0] <= grid_cols);
            seam_match[i] = seam_valid[i] && (seam_reg[i][7:0] == col1);
        end
        for (int i = 0; i < MAX_SEAMS; i++) begin
            below = '0;
            for (int j = 0; j < i; j++) begin
                below[j] = seam_valid[j];
            end
            rank_arr[i] = KW'($countones(below));
        end
        hit_next  = |seam_match;
        rank_next = '0;
        for (int i = 0; i < MAX_SEAMS; i++) begin
            if (seam_match[i]) begin
                rank_next = rank_arr[i];
            end
        end
        p_ok_next = ({1'b0, req.p} < {6'd0, active_count})
                    && ({1'b0, req.p} < 17'(ACTIVE_DEPTH));
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            p_ok_reg      <= p_ok_next;
            seam_hit_reg  <= hit_next;
            seam_rank_reg <= rank_next;
        end
    end

    assign clearing  = clearing_reg;
    assign act_bit   = act_bit_reg;
    assign p_ok      = p_ok_reg;
    assign seam_hit  = seam_hit_reg;
    assign seam_rank = seam_rank_reg;

endmodule

>>> rtl/grid_quad_index_generator.sv
// Quad index generator: for each in-grid quad request it returns the four corner
// vertex indices (right-edge corners on a seam column take the seam duplicate)
// and the parent-cell active flag. Throughput is one item per clock while m_ready
// does not stall; a request passes through the input register, the eight
// one-bit-per-stage quotient stages of the parent-cell divide and the multiply,
// table-lookup, seam-offset and output stages. Load items (active bit and seam
// entry writes) flow through the same pipeline and update the tables in the
// lookup stage, so later requests always see them; they, mode 3 items and
// requests outside the grid give no result. After reset s_ready stays low
// while the active bitmap is cleared one entry per cycle.
// Write configuration only while the pipeline is empty.
module grid_quad_index_generator
    import gqig_pkg::*;
#(
    parameter int ACTIVE_DEPTH = 1024,
    parameter int MAX_SEAMS    = 8
)
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [10:0]             cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic [7:0]              s_quad_row,
    input  logic [7:0]              s_quad_col,
    input  logic [9:0]              s_table_index,
    input  logic signed [8:0]       s_table_value,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_corner_bl,
    output logic [IDX_W-1:0]        m_corner_br,
    output logic [IDX_W-1:0]        m_corner_tr,
    output logic [IDX_W-1:0]        m_corner_tl,
    output logic                    m_quad_active
);

    localparam int KW = (MAX_SEAMS > 1) ? $clog2(MAX_SEAMS) : 1;

    logic [7:0]         grid_cols_reg;
    logic [7:0]         grid_rows_reg;
    logic [7:0]         cell_subdiv_reg;
    logic [10:0]        active_count_reg;
    logic [3:0]         seam_count_reg;

    logic [8:0]         per_row_reg;
    logic [8:0]         rp1_reg;
    logic [IDX_W-1:0]   vcount_reg;
    logic [7:0]         div_d_reg;

    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] valid_next;
    logic [N_STAGES-1:0] en;
    item_t               item_reg  [ST_S+1];
    item_t               item_next [ST_S+1];

    logic [DIV_W-1:0]   q_row;
    logic [DIV_W-1:0]   q_col;
    logic [DIV_W-1:0]   q_cols;
    logic [P_W-1:0]     p_reg;
    tbl_req_t           tbl_req;
    logic               clearing;
    logic               act_bit;
    logic               p_ok;
    logic               seam_hit;
    logic [KW-1:0]      seam_rank;

    logic               active_s_reg;
    logic               hit_s_reg;
    logic [IDX_W-1:0]   dupbase_s_reg;

    logic [IDX_W-1:0]   bl_o_reg;
    logic [IDX_W-1:0]   br_o_reg;
    logic [IDX_W-1:0]   tr_o_reg;
    logic [IDX_W-1:0]   tl_o_reg;
    logic               active_o_reg;

    logic               keep;
    item_kind_t         in_kind;
    logic [IDX_W-1:0]   row17;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg    <= 8'd1;
            grid_rows_reg    <= 8'd1;
            cell_subdiv_reg  <= 8'd0;
            active_count_reg <= 11'd0;
            seam_count_reg   <= 4'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GRID_COLS:    grid_cols_reg    <= cfg_wdata[7:0];
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_wdata[7:0];
                CFG_CELL_SUBDIV:  cell_subdiv_reg  <= cfg_wdata[7:0];
                CFG_ACTIVE_COUNT: active_count_reg <= cfg_wdata;
                CFG_SEAM_COUNT:   seam_count_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Values derived from configuration, registered; vcount_reg is formed from the registered per_row_reg and rp1_reg
    always_ff @(posedge aclk) begin
        per_row_reg <= {1'b0, grid_cols_reg} + 9'd1;
        rp1_reg     <= {1'b0, grid_rows_reg} + 9'd1;
        vcount_reg  <= IDX_W'(18'(per_row_reg) * 18'(rp1_reg));
        div_d_reg   <= (cell_subdiv_reg == 8'd0) ? 8'd1 : cell_subdiv_reg;
    end

    // Input decode; drop mode 3 and out-of-grid requests at the door
    always_comb begin
        in_kind = KIND_QUAD;
        keep    = 1'b0;
        case (s_mode)
            MODE_QUAD: begin
                in_kind = KIND_QUAD;
                keep    = (s_quad_row < grid_rows_reg) && (s_quad_col < grid_cols_reg);
            end
            MODE_ACTIVE_WR: begin
                in_kind = KIND_ACTIVE_WR;
                keep    = 1'b1;
            end
            MODE_SEAM_WR: begin
                in_kind = KIND_SEAM_WR;
                keep    = 1'b1;
            end
            default: begin
                in_kind = KIND_QUAD;
                keep    = 1'b0;
            end
        endcase
    end

    // A stage loads when it is empty or its item moves on
    always_comb begin
        en[ST_O] = !valid_reg[ST_O] || m_ready;
        for (int k = ST_O - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[ST_IN] && !clearing;

    always_comb begin
        valid_next[ST_IN] = s_valid && s_ready && keep;
        for (int k = 1; k < N_STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
        // Load items end at the table stage
        valid_next[ST_S] = valid_reg[ST_R] && (item_reg[ST_R].kind == KIND_QUAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // Item payload line; corner base indices formed in the two stages after the input stage
    always_comb begin
        item_next[ST_IN].kind = in_kind;
        item_next[ST_IN].row  = s_quad_row;
        item_next[ST_IN].col  = s_quad_col;
        item_next[ST_IN].tix  = s_table_index;
        item_next[ST_IN].tval = s_table_value;
        item_next[ST_IN].bl   = '0;
        item_next[ST_IN].tl   = '0;
        for (int k = 1; k <= ST_S; k++) begin
            item_next[k] = item_reg[k-1];
        end
        item_next[1].bl = IDX_W'(IDX_W'(item_reg[0].row) * IDX_W'(per_row_reg)
                                 + IDX_W'(item_reg[0].col));
        item_next[2].tl = item_reg[1].bl + IDX_W'(per_row_reg);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= ST_S; k++) begin
            if (en[k]) begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    // Parent cell: row/d, col/d and grid_cols/d
    gqig_div_lane u_div_row (
        .aclk     (aclk),
        .stage_en (en[ST_DIV0 +: DIV_STAGES]),
        .divisor  (div_d_reg),
        .dividend (item_reg[ST_IN].row),
        .quotient (q_row)
    );

    gqig_div_lane u_div_col (
        .aclk     (aclk),
        .stage_en (en[ST_DIV0 +: DIV_STAGES]),
        .divisor  (div_d_reg),
        .dividend (item_reg[ST_IN].col),
        .quotient (q_col)
    );

    gqig_div_lane u_div_cols (
        .aclk     (aclk),
        .stage_en (en[ST_DIV0 +: DIV_STAGES]),
        .divisor  (div_d_reg),
        .dividend (grid_cols_reg),
        .quotient (q_cols)
    );

    always_ff @(posedge aclk) begin
        if (en[ST_P]) begin
            p_reg <= P_W'(P_W'(q_row) * P_W'(q_cols) + P_W'(q_col));
        end
    end

    assign tbl_req.valid = valid_reg[ST_P];
    assign tbl_req.kind  = item_reg[ST_P].kind;
    assign tbl_req.tix   = item_reg[ST_P].tix;
    assign tbl_req.tval  = item_reg[ST_P].tval;
    assign tbl_req.col   = item_reg[ST_P].col;
    assign tbl_req.p     = p_reg;

    gqig_tables #(
        .ACTIVE_DEPTH (ACTIVE_DEPTH),
        .MAX_SEAMS    (MAX_SEAMS)
    ) u_tables (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_en      (en[ST_R]),
        .req          (tbl_req),
        .grid_cols    (grid_cols_reg),
        .active_count (active_count_reg),
        .seam_count   (seam_count_reg),
        .clearing     (clearing),
        .act_bit      (act_bit),
        .p_ok         (p_ok),
        .seam_hit     (seam_hit),
        .seam_rank    (seam_rank)
    );

    // Seam duplicate base and active flag
    always_ff @(posedge aclk) begin
        if (en[ST_S]) begin
            active_s_reg  <= (active_count_reg == 11'd0) || (p_ok && act_bit);
            hit_s_reg     <= seam_hit;
            dupbase_s_reg <= IDX_W'(18'(vcount_reg) + 18'(seam_rank) * 18'(rp1_reg));
        end
    end

    assign row17 = IDX_W'(item_reg[ST_S].row);

    always_ff @(posedge aclk) begin
        if (en[ST_O]) begin
            bl_o_reg     <= item_reg[ST_S].bl;
            tl_o_reg     <= item_reg[ST_S].tl;
            br_o_reg     <= hit_s_reg ? dupbase_s_reg + row17
                                      : item_reg[ST_S].bl + IDX_W'(1);
            tr_o_reg     <= hit_s_reg ? dupbase_s_reg + row17 + IDX_W'(1)
                                      : item_reg[ST_S].tl + IDX_W'(1);
            active_o_reg <= active_s_reg;
        end
    end

    assign m_valid       = valid_reg[ST_O];
    assign m_corner_bl   = bl_o_reg;
    assign m_corner_br   = br_o_reg;
    assign m_corner_tr   = tr_o_reg;
    assign m_corner_tl   = tl_o_reg;
    assign m_quad_active = active_o_reg;

endmodule
